>>> rtl/lpfp_pkg.sv
// Shared types, constants and helper functions of the length-prefixed frame parser.
package lpfp_pkg;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [CfgIndexW-1:0] CFG_RESPONSE_CODE = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_ERROR_CODE    = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_MESSAGE_CODE  = 2'd2;

  localparam logic [3:0] BEAT_LEN     = 4'd11;
  localparam logic [3:0] BEAT_LAST    = 4'd10;
  localparam logic [7:0] HEADER_BYTES = 8'd4;

  typedef enum logic [1:0] {
    PH_SIZE    = 2'd0,
    PH_TYPE    = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_RESPONSE = 2'd0,
    KIND_ERROR    = 2'd1,
    KIND_MESSAGE  = 2'd2,
    KIND_UNKNOWN  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      frame_kind;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       frame_last;
    logic       heartbeat;
    logic       size_error;
  } result_t;

  // response beats error beats message when codes overlap
  function automatic kind_t kind_of(input logic [31:0] t, input logic [31:0] rc,
                                    input logic [31:0] ec, input logic [31:0] mc);
    kind_t k;
    if (t == rc) begin
      k = KIND_RESPONSE;
    end else if (t == ec) begin
      k = KIND_ERROR;
    end else if (t == mc) begin
      k = KIND_MESSAGE;
    end else begin
      k = KIND_UNKNOWN;
    end
    return k;
  endfunction

  // "_heartbeat_"
  function automatic logic [7:0] beat_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h5f;
      4'd1:    c = 8'h68;
      4'd2:    c = 8'h65;
      4'd3:    c = 8'h61;
      4'd4:    c = 8'h72;
      4'd5:    c = 8'h74;
      4'd6:    c = 8'h62;
      4'd7:    c = 8'h65;
      4'd8:    c = 8'h61;
      4'd9:    c = 8'h74;
      4'd10:   c = 8'h5f;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/lpfp_if.sv
// Valid/ready channel interfaces for the frame parser's byte input and result output.
interface lpfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface lpfp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_kind;
  logic [7:0] payload_byte;
  logic       byte_valid;
  logic       frame_last;
  logic       heartbeat;
  logic       size_error;

  modport source (output valid, output frame_kind, output payload_byte,
                  output byte_valid, output frame_last, output heartbeat,
                  output size_error, input ready);
  modport sink   (input valid, input frame_kind, input payload_byte,
                  input byte_valid, input frame_last, input heartbeat,
                  input size_error, output ready);
endinterface

>>> rtl/length_prefixed_frame_parser.sv
// Top level of the length-prefixed frame parser: header decode and payload pass-through.
//
// in_chan carries one stream byte per transfer. Each frame is a 4-byte big-endian
// size, a 4-byte big-endian type word and size-4 payload bytes. out_chan gives one
// result per payload byte, tagged with the frame kind from the three type codes
// written on the cfg_ port (index 0 response, 1 error, 2 message). A frame with an
// empty payload gives one result with byte_valid low; a size below 4 gives one
// result with size_error set and the frame is dropped. Header bytes give no result.
// Throughput: one byte per cycle while out_chan does not stall. A byte lands in
// the input register at its transfer and moves on to the output register once that
// register is free or being read, and its result is offered on out_chan from there.
// The output register and the input register form a two-entry buffer: when the
// receiver stalls, one more byte is taken, then in_chan.ready drops until
// out_chan moves.
// Synchronous reset (rst_n low) empties both registers, returns the parser to
// reading a frame size and loads the type codes with 0, 1 and 2.
module length_prefixed_frame_parser (
  input  logic                                 clk,
  input  logic                                 rst_n,
  lpfp_in_if.sink                              in_chan,
  lpfp_out_if.source                           out_chan,
  input  logic                                 cfg_wr_en,
  input  logic [lpfp_pkg::CfgIndexW-1:0]       cfg_index,
  input  logic [lpfp_pkg::CfgDataW-1:0]        cfg_wr_data
);

  logic [31:0] resp_code_r, err_code_r, msg_code_r;

  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              out_valid_r;
  lpfp_pkg::result_t res_r;

  lpfp_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]       hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [23:0]      type_r, type_nxt;
  lpfp_pkg::kind_t  kind_r, kind_nxt;
  logic             beat_match_r, beat_match_nxt;
  logic [3:0]       beat_pos_r, beat_pos_nxt;

  logic              stage_go;
  logic              res_fire;
  lpfp_pkg::result_t res_nxt;
  logic [1:0]        hdr_base;
  logic              hdr_full;
  logic [31:0]       size_word;
  logic [31:0]       type_word;
  lpfp_pkg::kind_t   type_kind;
  logic              char_ok;
  logic              pay_last;

  assign stage_go      = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || stage_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_code_r <= 32'd0;
      err_code_r  <= 32'd1;
      msg_code_r  <= 32'd2;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lpfp_pkg::CFG_RESPONSE_CODE: resp_code_r <= cfg_wr_data;
        lpfp_pkg::CFG_ERROR_CODE:    err_code_r  <= cfg_wr_data;
        lpfp_pkg::CFG_MESSAGE_CODE:  msg_code_r  <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_valid_r <= 1'b1;
    end else if (stage_go) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_byte_r <= in_chan.data_byte;
    end
  end

  assign hdr_base  = (phase_r == lpfp_pkg::PH_SIZE || phase_r == lpfp_pkg::PH_TYPE) ?
                     hdr_cnt_r : 2'd0;
  assign hdr_full  = (hdr_base == 2'd3);
  assign size_word = {rem_r[23:0], in_byte_r};
  assign type_word = {type_r, in_byte_r};
  assign type_kind = lpfp_pkg::kind_of(type_word, resp_code_r, err_code_r, msg_code_r);
  assign char_ok   = beat_match_r && (beat_pos_r < lpfp_pkg::BEAT_LEN) &&
                     (lpfp_pkg::beat_char(beat_pos_r) == in_byte_r);
  assign pay_last  = (rem_r == 32'd1);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      lpfp_pkg::PH_TYPE: begin
        if (hdr_full) begin
          phase_nxt = (rem_r == 32'd0) ? lpfp_pkg::PH_SIZE : lpfp_pkg::PH_PAYLOAD;
        end
      end
      lpfp_pkg::PH_PAYLOAD: begin
        if (pay_last) begin
          phase_nxt = lpfp_pkg::PH_SIZE;
        end
      end
      default: begin
        phase_nxt = (hdr_full && size_word[31:2] != 30'd0) ?
                    lpfp_pkg::PH_TYPE : lpfp_pkg::PH_SIZE;
      end
    endcase
  end

  // datapath and result
  always_comb begin
    hdr_cnt_nxt    = hdr_base + 2'd1;
    rem_nxt        = rem_r;
    type_nxt       = type_r;
    kind_nxt       = kind_r;
    beat_match_nxt = beat_match_r;
    beat_pos_nxt   = beat_pos_r;
    res_fire       = 1'b0;
    res_nxt        = '0;
    case (phase_r)
      lpfp_pkg::PH_TYPE: begin
        type_nxt = type_word[23:0];
        if (hdr_full) begin
          kind_nxt = type_kind;
          if (rem_r == 32'd0) begin
            res_fire           = 1'b1;
            res_nxt.frame_kind = type_kind;
            res_nxt.frame_last = 1'b1;
          end else begin
            beat_match_nxt = 1'b1;
            beat_pos_nxt   = 4'd0;
          end
        end
      end
      lpfp_pkg::PH_PAYLOAD: begin
        hdr_cnt_nxt = 2'd0;
        if (char_ok) begin
          beat_pos_nxt = beat_pos_r + 4'd1;
        end else begin
          beat_match_nxt = 1'b0;
        end
        rem_nxt              = rem_r - 32'd1;
        res_fire             = 1'b1;
        res_nxt.frame_kind   = kind_r;
        res_nxt.payload_byte = in_byte_r;
        res_nxt.byte_valid   = 1'b1;
        res_nxt.frame_last   = pay_last;
        res_nxt.heartbeat    = pay_last && char_ok && (beat_pos_r == lpfp_pkg::BEAT_LAST) &&
                               (kind_r == lpfp_pkg::KIND_RESPONSE ||
                                kind_r == lpfp_pkg::KIND_ERROR);
      end
      default: begin
        rem_nxt = size_word;
        if (hdr_full) begin
          if (size_word[31:2] == 30'd0) begin
            rem_nxt            = 32'd0;
            res_fire           = 1'b1;
            res_nxt.frame_last = 1'b1;
            res_nxt.size_error = 1'b1;
          end else begin
            rem_nxt  = size_word - {24'd0, lpfp_pkg::HEADER_BYTES};
            type_nxt = 24'd0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= lpfp_pkg::PH_SIZE;
      hdr_cnt_r    <= 2'd0;
      rem_r        <= 32'd0;
      type_r       <= 24'd0;
      kind_r       <= lpfp_pkg::KIND_RESPONSE;
      beat_match_r <= 1'b1;
      beat_pos_r   <= 4'd0;
    end else if (stage_go) begin
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      rem_r        <= rem_nxt;
      type_r       <= type_nxt;
      kind_r       <= kind_nxt;
      beat_match_r <= beat_match_nxt;
      beat_pos_r   <= beat_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_go) begin
      out_valid_r <= res_fire;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && res_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.frame_kind   = res_r.frame_kind;
  assign out_chan.payload_byte = res_r.payload_byte;
  assign out_chan.byte_valid   = res_r.byte_valid;
  assign out_chan.frame_last   = res_r.frame_last;
  assign out_chan.heartbeat    = res_r.heartbeat;
  assign out_chan.size_error   = res_r.size_error;

`ifndef SYNTHESIS
  a_payload_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == lpfp_pkg::PH_PAYLOAD |-> rem_r != 32'd0)
    else $error("payload phase with no bytes left");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    stage_go && res_fire |=> out_valid_r)
    else $error("result lost between stage and output register");

  a_size_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.size_error |-> res_r.frame_last && !res_r.byte_valid)
    else $error("size error result malformed");

  a_heartbeat_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.heartbeat |-> res_r.frame_last && res_r.byte_valid &&
      (res_r.frame_kind == lpfp_pkg::KIND_RESPONSE ||
       res_r.frame_kind == lpfp_pkg::KIND_ERROR))
    else $error("heartbeat on wrong result");

  a_header_end_phase: assert property (@(posedge clk) disable iff (!rst_n)
    stage_go && phase_r == lpfp_pkg::PH_TYPE && !hdr_full |=> phase_r == lpfp_pkg::PH_TYPE)
    else $error("type header left early");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench of the length-prefixed frame parser: byte stream in, results checked.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [lpfp_pkg::CfgIndexW-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam logic [87:0]          BEAT_TEXT      = "_heartbeat_";
  localparam int                   BEAT_BYTES     = 11;
  localparam int unsigned          STALL_LIMIT    = 400;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_wr_en;
  logic [lpfp_pkg::CfgIndexW-1:0] cfg_index;
  logic [lpfp_pkg::CfgDataW-1:0]  cfg_wr_data;

  lpfp_in_if  in_chan ();
  lpfp_out_if out_chan ();

  length_prefixed_frame_parser i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  logic [7:0]        stream_bytes[$];
  logic [7:0]        frame_payload[$];
  lpfp_pkg::result_t pending_results[$];
  lpfp_pkg::result_t want;

  logic [31:0] rsp_code = 32'd0;
  logic [31:0] err_code = 32'd1;
  logic [31:0] msg_code = 32'd2;

  lpfp_pkg::phase_t prs_phase  = lpfp_pkg::PH_SIZE;
  logic [1:0]  hdr_cnt    = 2'd0;
  logic [31:0] bytes_left = 32'd0;
  logic [31:0] frame_type = 32'd0;
  logic        beat_ok    = 1'b1;
  int          beat_pos   = 0;

  int unsigned fail_cnt    = 0;
  int unsigned idle_cycles = 0;
  int unsigned gen_bytes   = 0;
  int          tx_gap      = 0;
  int          rx_wait     = 0;
  bit          tx_burst    = 1'b0;
  bit          rx_burst    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // response wins over error, error over message
  function automatic lpfp_pkg::kind_t classify_type(input logic [31:0] t);
    if (t == rsp_code) return lpfp_pkg::KIND_RESPONSE;
    if (t == err_code) return lpfp_pkg::KIND_ERROR;
    if (t == msg_code) return lpfp_pkg::KIND_MESSAGE;
    return lpfp_pkg::KIND_UNKNOWN;
  endfunction

  function automatic void expect_result(input lpfp_pkg::kind_t k, input logic [7:0] b,
                                        input logic v, input logic last, input logic hb,
                                        input logic serr);
    lpfp_pkg::result_t r;
    r = '{k, b, v, last, hb, serr};
    pending_results.push_back(r);
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    lpfp_pkg::kind_t k;
    logic  hb;
    k  = classify_type(frame_type);
    hb = 1'b0;
    case (prs_phase)
      lpfp_pkg::PH_TYPE: begin
        frame_type = {frame_type[23:0], b};
        hdr_cnt    = hdr_cnt + 2'd1;
        if (hdr_cnt == 2'd0) begin
          if (bytes_left == 32'd0) begin
            prs_phase = lpfp_pkg::PH_SIZE;
            expect_result(classify_type(frame_type), 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
          end else begin
            prs_phase = lpfp_pkg::PH_PAYLOAD;
            beat_ok   = 1'b1;
            beat_pos  = 0;
          end
        end
      end
      lpfp_pkg::PH_PAYLOAD: begin
        if (beat_ok && beat_pos < BEAT_BYTES &&
            BEAT_TEXT[8*(BEAT_BYTES-1-beat_pos) +: 8] == b) begin
          beat_pos = beat_pos + 1;
        end else begin
          beat_ok = 1'b0;
        end
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 32'd0) begin
          hb        = beat_ok && beat_pos == BEAT_BYTES &&
                      (k == lpfp_pkg::KIND_RESPONSE || k == lpfp_pkg::KIND_ERROR);
          prs_phase = lpfp_pkg::PH_SIZE;
          hdr_cnt   = 2'd0;
          expect_result(k, b, 1'b1, 1'b1, hb, 1'b0);
        end else begin
          expect_result(k, b, 1'b1, 1'b0, 1'b0, 1'b0);
        end
      end
      default: begin
        prs_phase  = lpfp_pkg::PH_SIZE;
        bytes_left = {bytes_left[23:0], b};
        hdr_cnt    = hdr_cnt + 2'd1;
        if (hdr_cnt == 2'd0) begin
          if (bytes_left < 32'd4) begin
            bytes_left = 32'd0;
            expect_result(lpfp_pkg::KIND_RESPONSE, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
          end else begin
            bytes_left = bytes_left - 32'd4;
            frame_type = 32'd0;
            prs_phase  = lpfp_pkg::PH_TYPE;
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string fname, input logic [7:0] exp_val,
                                      input logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", fname, exp_val, act_val);
      fail_cnt++;
    end
  endfunction

  // sender: one byte per transfer, random gap drawn per byte
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid     <= 1'b0;
      in_chan.data_byte <= 8'h00;
      tx_gap = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        parse_byte(in_chan.data_byte);
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_chan.valid <= 1'b0;
        end else if (stream_bytes.size() != 0) begin
          in_chan.valid     <= 1'b1;
          in_chan.data_byte <= stream_bytes.pop_front();
          if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 3);
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: compare each transfer with the oldest expectation, then stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: kind %0h byte %0h valid %0b last %0b beat %0b serr %0b",
                 out_chan.frame_kind, out_chan.payload_byte, out_chan.byte_valid,
                 out_chan.frame_last, out_chan.heartbeat, out_chan.size_error);
          fail_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("frame_kind", 8'(want.frame_kind), 8'(out_chan.frame_kind));
          check_field("payload_byte", want.payload_byte, out_chan.payload_byte);
          check_field("byte_valid", 8'(want.byte_valid), 8'(out_chan.byte_valid));
          check_field("frame_last", 8'(want.frame_last), 8'(out_chan.frame_last));
          check_field("heartbeat", 8'(want.heartbeat), 8'(out_chan.heartbeat));
          check_field("size_error", 8'(want.size_error), 8'(out_chan.size_error));
        end
        if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 3);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("length_prefixed_frame_parser test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic set_codes(input logic [31:0] rc, input logic [31:0] ec, input logic [31:0] mc);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= lpfp_pkg::CFG_RESPONSE_CODE;
    cfg_wr_data <= rc;
    @(posedge clk);
    cfg_index   <= lpfp_pkg::CFG_ERROR_CODE;
    cfg_wr_data <= ec;
    @(posedge clk);
    cfg_index   <= lpfp_pkg::CFG_MESSAGE_CODE;
    cfg_wr_data <= mc;
    @(posedge clk);
    cfg_index   <= CFG_UNUSED_IDX;
    cfg_wr_data <= $urandom;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    rsp_code = rc;
    err_code = ec;
    msg_code = mc;
  endtask

  task automatic wait_idle();
    while (stream_bytes.size() != 0 || in_chan.valid || pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) stream_bytes.push_back(w[8*i +: 8]);
    gen_bytes += 4;
  endtask

  task automatic add_frame(input logic [31:0] ftype);
    push_word(32'(frame_payload.size() + 4));
    push_word(ftype);
    foreach (frame_payload[i]) stream_bytes.push_back(frame_payload[i]);
    gen_bytes += frame_payload.size();
    frame_payload.delete();
  endtask

  task automatic load_beat();
    for (int i = 0; i < BEAT_BYTES; i++) begin
      frame_payload.push_back(BEAT_TEXT[8*(BEAT_BYTES-1-i) +: 8]);
    end
  endtask

  function automatic logic [31:0] pick_type();
    logic [31:0] base;
    case ($urandom_range(0, 2))
      0:       base = rsp_code;
      1:       base = err_code;
      default: base = msg_code;
    endcase
    case ($urandom_range(0, 5))
      3:       return $urandom;
      4:       return base ^ (32'd1 << $urandom_range(0, 31));
      5:       return $urandom_range(0, 3);
      default: return base;
    endcase
  endfunction

  // mostly well-formed frames; some undersized, some near-heartbeat payloads
  task automatic add_random(input int unsigned target);
    int unsigned start;
    int unsigned sel;
    int unsigned plen;
    start = gen_bytes;
    while (gen_bytes - start < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        push_word($urandom_range(0, 3));
      end else begin
        if (sel < 22) begin
          load_beat();
          case ($urandom_range(0, 4))
            2: frame_payload[$urandom_range(0, BEAT_BYTES-1)] = 8'($urandom_range(0, 255));
            3: repeat ($urandom_range(1, 10)) frame_payload.delete(frame_payload.size() - 1);
            4: frame_payload.push_back(8'($urandom_range(0, 255)));
            default: ;
          endcase
        end else begin
          plen = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
          repeat (plen) frame_payload.push_back(8'($urandom_range(0, 255)));
        end
        add_frame(pick_type());
      end
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= '0;
    cfg_wr_data       <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset codes: undersized, empty, heartbeat per kind, byte extremes
    for (int s = 0; s < 4; s++) push_word(32'(s));
    add_frame(32'd0);
    add_frame(32'd1);
    add_frame(32'd2);
    add_frame(32'hFFFF_FFFF);
    load_beat();
    add_frame(32'd0);
    load_beat();
    add_frame(32'd1);
    load_beat();
    add_frame(32'd2);
    load_beat();
    add_frame(32'h0000_0100);
    frame_payload.push_back(8'h00);
    add_frame(32'd2);
    frame_payload.push_back(8'hFF);
    add_frame(32'd0);
    load_beat();
    frame_payload.delete(frame_payload.size() - 1);
    add_frame(32'd0);
    load_beat();
    frame_payload.push_back("!");
    add_frame(32'd1);
    frame_payload = '{8'hFF, 8'h00, 8'hAA, 8'h55};
    add_frame(32'h8000_0000);
    wait_idle();

    set_codes(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0001);
    add_random(400);
    wait_idle();
    set_codes(32'h0000_0007, 32'h0000_0007, 32'h0000_0007);
    add_random(200);
    wait_idle();
    set_codes(32'h0000_0000, 32'hA5A5_5A5A, 32'hA5A5_5A5A);
    add_random(200);
    wait_idle();
    set_codes($urandom, $urandom, $urandom_range(0, 3));
    add_random(400);
    wait_idle();
    set_codes(32'd0, 32'd1, 32'd2);
    add_random(250);
    wait_idle();

    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("length_prefixed_frame_parser test passed");
    end else begin
      $display("length_prefixed_frame_parser test failed");
    end
    $finish;
  end

endmodule
